// ===== hdl/sacl_pkg.sv =====
// Shared types and constants for the set-associative LRU cache tag model.
package sacl_pkg;

    localparam int DEF_MAX_SET_BITS = 10;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_BITS    = 64;

    localparam int OP_W       = 2;
    localparam int IN_ADDR_W  = 64;
    localparam int WAY_OUT_W  = 3;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SETB_W     = 4;
    localparam int WAYS_W     = 4;
    localparam int OFFB_W     = 6;

    localparam logic [SETB_W-1:0] RST_SET_BITS = 4'd4;
    localparam logic [WAYS_W-1:0] RST_WAYS     = 4'd1;
    localparam logic [OFFB_W-1:0] RST_OFF_BITS = 6'd4;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS = 2'd0,
        CFG_WAYS     = 2'd1,
        CFG_OFF_BITS = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_LOOK2
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [IN_ADDR_W-1:0] address;
    } t_in;

    typedef struct packed {
        logic                 was_hit;
        logic                 evicted;
        logic [WAY_OUT_W-1:0] way_used;
        logic [TOTAL_W-1:0]   hit_total;
        logic [TOTAL_W-1:0]   miss_total;
        logic [TOTAL_W-1:0]   eviction_total;
        logic                 last_of_run;
    } t_out;

    typedef struct packed {
        logic hit;
        logic evict;
    } t_look_flags;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
    endfunction

endpackage

// ===== hdl/sacl_lookup.sv =====
// Tag compare, victim choice and LRU rank update for one set row.
module sacl_lookup #(
    parameter int MAX_WAYS  = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS,
    parameter int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    parameter int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    parameter int WCNT_W    = $clog2(MAX_WAYS + 1)
) (
    input  logic [MAX_WAYS-1:0]                valid_in,
    input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_in,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]    rank_in,
    input  logic [ADDR_BITS-1:0]               tag,
    input  logic [WCNT_W-1:0]                  ways_eff,
    output logic [MAX_WAYS-1:0]                valid_out,
    output logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_out,
    output logic [MAX_WAYS-1:0][RANK_W-1:0]    rank_out,
    output sacl_pkg::t_look_flags              flags,
    output logic [WAY_W-1:0]                   way
);

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] free_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    lru_way;
    logic [RANK_W-1:0]   best_rank;
    logic [RANK_W-1:0]   sel_rank;
    logic                hit;
    logic                any_free;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w]   = ways_eff > WCNT_W'(w);
            hit_vec[w]  = in_use[w] && valid_in[w] && (tag_in[w] == tag);
            free_vec[w] = in_use[w] && !valid_in[w];
        end
        hit      = |hit_vec;
        any_free = |free_vec;

        hit_way  = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (free_vec[w]) begin
                free_way = WAY_W'(w);
            end
        end

        best_rank = rank_in[0];
        lru_way   = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && (rank_in[w] > best_rank)) begin
                best_rank = rank_in[w];
                lru_way   = WAY_W'(w);
            end
        end

        if (hit) begin
            way = hit_way;
        end else if (any_free) begin
            way = free_way;
        end else begin
            way = lru_way;
        end
        sel_rank = rank_in[way];

        valid_out = valid_in;
        tag_out   = tag_in;
        rank_out  = rank_in;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == way) begin
                valid_out[w] = 1'b1;
                tag_out[w]   = tag;
                rank_out[w]  = '0;
            end else if (in_use[w] && valid_in[w]) begin
                if (!hit && any_free) begin
                    if (rank_in[w] < RANK_MAX) begin
                        rank_out[w] = rank_in[w] + RANK_W'(1);
                    end
                end else if (rank_in[w] < sel_rank) begin
                    rank_out[w] = rank_in[w] + RANK_W'(1);
                end
            end
        end

        flags.hit   = hit;
        flags.evict = !hit && !any_free;
    end

endmodule

// ===== hdl/set_assoc_cache_lru_sim.sv =====
// Top level of the set-associative cache tag store with true-LRU replacement.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------
//  access   | start in, busy out         | i_in (operation, address)
//  result   | o_result_valid strobe      | o_result (hit, eviction, totals)
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A load or store passes through S_LOOK, a modify through S_LOOK and S_LOOK2. The set row
// is read from the tag memory at the accepting edge, and each lookup state then compares,
// updates and writes the row back. The result strobe is registered and rises in the cycle
// after each lookup. After reset a clearing pass writes every row (2**MAX_SET_BITS rows,
// 1024 by default) with busy high. Results cannot be stalled.
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS    = sacl_pkg::DEF_ADDR_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sacl_pkg::t_in                  i_in,
    output logic                           o_result_valid,
    output sacl_pkg::t_out                 o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int ROW_W    = MAX_WAYS * (1 + ADDR_BITS + RANK_W);
    localparam int TAGS_W   = MAX_WAYS * ADDR_BITS;
    localparam int RANKS_W  = MAX_WAYS * RANK_W;
    localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(NUM_SETS - 1);

    logic [ROW_W-1:0] mem [NUM_SETS];
    logic [ROW_W-1:0] r_rdata;
    logic [ROW_W-1:0] r_row;

    sacl_pkg::t_state r_state, n_state;

    logic [sacl_pkg::SETB_W-1:0] r_set_bits;
    logic [sacl_pkg::WAYS_W-1:0] r_ways;
    logic [sacl_pkg::OFFB_W-1:0] r_off_bits;

    logic [SET_AW-1:0]            r_clr;
    logic [SET_AW-1:0]            r_set;
    logic [ADDR_BITS-1:0]         r_tag;
    logic                         r_modify;
    logic [sacl_pkg::TOTAL_W-1:0] r_hits, n_hits;
    logic [sacl_pkg::TOTAL_W-1:0] r_misses, n_misses;
    logic [sacl_pkg::TOTAL_W-1:0] r_evicts, n_evicts;
    logic                         r_out_valid;
    sacl_pkg::t_out               r_out;

    logic [sacl_pkg::SETB_W-1:0] sb_eff;
    logic [WCNT_W-1:0]           ways_eff;
    logic [ADDR_BITS-1:0]        addr;
    logic [6:0]                  tag_shift;
    logic [SET_AW-1:0]           set_mask;
    logic [SET_AW-1:0]           dec_set;
    logic [ADDR_BITS-1:0]        dec_tag;
    logic                        accept;
    logic                        is_access;
    logic                        is_modify;

    logic [ROW_W-1:0]                   row_in;
    logic [MAX_WAYS-1:0]                lk_valid;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] lk_tag;
    logic [MAX_WAYS-1:0][RANK_W-1:0]    lk_rank;
    logic [ROW_W-1:0]                   row_new;
    sacl_pkg::t_look_flags              lk_flags;
    logic [WAY_W-1:0]                   lk_way;

    logic              mem_we;
    logic [SET_AW-1:0] mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic              lookup_now;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= sacl_pkg::RST_SET_BITS;
            r_ways     <= sacl_pkg::RST_WAYS;
            r_off_bits <= sacl_pkg::RST_OFF_BITS;
        end else if (i_cfg_valid) begin
            unique case (sacl_pkg::t_cfg_idx'(i_cfg_index))
                sacl_pkg::CFG_SET_BITS: r_set_bits <= i_cfg_data[sacl_pkg::SETB_W-1:0];
                sacl_pkg::CFG_WAYS:     r_ways     <= i_cfg_data[sacl_pkg::WAYS_W-1:0];
                sacl_pkg::CFG_OFF_BITS: r_off_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sb_eff = (32'(r_set_bits) > MAX_SET_BITS) ? sacl_pkg::SETB_W'(MAX_SET_BITS)
                                                  : r_set_bits;
        if (r_ways == '0) begin
            ways_eff = WCNT_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WCNT_W'(r_ways);
        end

        addr      = i_in.address[ADDR_BITS-1:0];
        tag_shift = 7'(r_off_bits) + 7'(sb_eff);
        set_mask  = ~({SET_AW{1'b1}} << sb_eff);
        dec_set   = (32'(r_off_bits) < ADDR_BITS) ? (SET_AW'(addr >> r_off_bits) & set_mask)
                                                  : '0;
        dec_tag   = (32'(tag_shift) < ADDR_BITS) ? (addr >> tag_shift) : '0;

        is_access = 1'b0;
        is_modify = 1'b0;
        unique case (sacl_pkg::t_op'(i_in.operation))
            sacl_pkg::OP_LOAD, sacl_pkg::OP_STORE: is_access = 1'b1;
            sacl_pkg::OP_MODIFY: begin
                is_access = 1'b1;
                is_modify = 1'b1;
            end
            default: ;
        endcase
    end

    assign busy   = (r_state != sacl_pkg::S_IDLE);
    assign accept = start && !busy;

    assign row_in   = (r_state == sacl_pkg::S_LOOK2) ? r_row : r_rdata;
    assign lk_valid = row_in[ROW_W-1 -: MAX_WAYS];
    assign lk_tag   = row_in[RANKS_W +: TAGS_W];
    assign lk_rank  = row_in[0 +: RANKS_W];

    sacl_lookup #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .RANK_W    (RANK_W),
        .WAY_W     (WAY_W),
        .WCNT_W    (WCNT_W)
    ) u_lookup (
        .valid_in  (lk_valid),
        .tag_in    (lk_tag),
        .rank_in   (lk_rank),
        .tag       (r_tag),
        .ways_eff  (ways_eff),
        .valid_out (row_new[ROW_W-1 -: MAX_WAYS]),
        .tag_out   (row_new[RANKS_W +: TAGS_W]),
        .rank_out  (row_new[0 +: RANKS_W]),
        .flags     (lk_flags),
        .way       (lk_way)
    );

    always_comb begin
        n_state    = r_state;
        mem_we     = 1'b0;
        mem_waddr  = r_set;
        mem_wdata  = row_new;
        lookup_now = 1'b0;
        unique case (r_state)
            sacl_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == LAST_SET) begin
                    n_state = sacl_pkg::S_IDLE;
                end
            end
            sacl_pkg::S_IDLE: begin
                if (accept && is_access) begin
                    n_state = sacl_pkg::S_LOOK;
                end
            end
            sacl_pkg::S_LOOK: begin
                mem_we     = 1'b1;
                lookup_now = 1'b1;
                n_state    = r_modify ? sacl_pkg::S_LOOK2 : sacl_pkg::S_IDLE;
            end
            sacl_pkg::S_LOOK2: begin
                mem_we     = 1'b1;
                lookup_now = 1'b1;
                n_state    = sacl_pkg::S_IDLE;
            end
            default: n_state = sacl_pkg::S_IDLE;
        endcase

        n_hits   = lk_flags.hit ? sacl_pkg::sat_inc(r_hits) : r_hits;
        n_misses = lk_flags.hit ? r_misses : sacl_pkg::sat_inc(r_misses);
        n_evicts = lk_flags.evict ? sacl_pkg::sat_inc(r_evicts) : r_evicts;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rdata <= mem[dec_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sacl_pkg::S_CLEAR;
            r_clr       <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
            r_modify    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= lookup_now;
            if (r_state == sacl_pkg::S_CLEAR) begin
                r_clr <= r_clr + SET_AW'(1);
            end
            if (accept) begin
                r_modify <= is_modify;
            end
            if (lookup_now) begin
                r_hits   <= n_hits;
                r_misses <= n_misses;
                r_evicts <= n_evicts;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= dec_set;
            r_tag <= dec_tag;
        end
        if (lookup_now) begin
            r_row                <= row_new;
            r_out.was_hit        <= lk_flags.hit;
            r_out.evicted        <= lk_flags.evict;
            r_out.way_used       <= sacl_pkg::WAY_OUT_W'(lk_way);
            r_out.hit_total      <= n_hits;
            r_out.miss_total     <= n_misses;
            r_out.eviction_total <= n_evicts;
            r_out.last_of_run    <= (r_state == sacl_pkg::S_LOOK2) || !r_modify;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef SYNTHESIS
    a_strobe_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == sacl_pkg::S_LOOK
                            || $past(r_state) == sacl_pkg::S_LOOK2))
        else $error("Result strobe without a lookup in the previous cycle.");

    a_modify_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last_of_run)
            |=> (o_result_valid && o_result.last_of_run))
        else $error("First beat of a modify not followed by its final beat.");

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.evicted) |-> !o_result.was_hit)
        else $error("Eviction reported on a hit.");
`endif

endmodule

// ===== bench/tb_set_assoc_cache_lru_sim.sv =====
// Self-checking testbench for the set-associative cache tag store with true-LRU replacement.
module tb_set_assoc_cache_lru_sim;

    localparam int SET_BITS_MAX = sacl_pkg::DEF_MAX_SET_BITS;
    localparam int WAYS_MAX     = sacl_pkg::DEF_MAX_WAYS;
    localparam int ADDR_W       = sacl_pkg::DEF_ADDR_BITS;
    localparam int LINES        = (1 << SET_BITS_MAX) * WAYS_MAX;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int QUIET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [sacl_pkg::OP_W-1:0]      OP_UNKNOWN = 2'd3;
    localparam logic [sacl_pkg::CFG_IDX_W-1:0] CFG_NONE   = 2'd3;
    localparam logic [sacl_pkg::IN_ADDR_W-1:0] ALL_ONES   = '1;

    typedef struct {
        logic                           is_cfg;
        logic [sacl_pkg::OP_W-1:0]      code;
        logic [sacl_pkg::IN_ADDR_W-1:0] value;
        logic                           has_typed;
        sacl_pkg::t_out                 typed;
    } t_stim_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    sacl_pkg::t_in                   i_in = '0;
    logic                            o_result_valid;
    sacl_pkg::t_out                  o_result;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    logic                         tag_valid [LINES];
    logic [ADDR_W-1:0]            tag_store [LINES];
    logic [2:0]                   lru_rank  [LINES];
    logic [sacl_pkg::TOTAL_W-1:0] hit_tally;
    logic [sacl_pkg::TOTAL_W-1:0] miss_tally;
    logic [sacl_pkg::TOTAL_W-1:0] evict_count;
    logic [sacl_pkg::SETB_W-1:0]  set_bits_reg;
    logic [sacl_pkg::WAYS_W-1:0]  ways_reg;
    logic [sacl_pkg::OFFB_W-1:0]  off_bits_reg;

    sacl_pkg::t_out pending_results [$];
    t_stim_row      stim_rows [$];
    logic           allow_idle = 1'b1;
    int             cycle_count = 0;
    int             mismatch_count = 0;
    int             results_checked = 0;
    int             accesses_done = 0;
    int             ignored_done = 0;
    int             cfg_writes = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    set_assoc_cache_lru_sim DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_in           (i_in),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    function automatic logic [sacl_pkg::TOTAL_W-1:0] count_up(
        input logic [sacl_pkg::TOTAL_W-1:0] v);
        return (v == sacl_pkg::TOTAL_MAX) ? v : v + sacl_pkg::TOTAL_W'(1);
    endfunction

    function automatic int active_ways();
        if (ways_reg == 0) begin
            return 1;
        end
        return (int'(ways_reg) > WAYS_MAX) ? WAYS_MAX : int'(ways_reg);
    endfunction

    function automatic sacl_pkg::t_out lru_lookup(input logic [ADDR_W-1:0] addr,
                                                  input logic last_one);
        int                sb;
        int                ob;
        int                nways;
        int                base;
        int                w;
        int                way;
        int                best;
        logic [ADDR_W-1:0] set_idx;
        logic [ADDR_W-1:0] tag;
        logic              hit;
        logic              evict;
        logic              free_found;
        logic [2:0]        r;
        sacl_pkg::t_out    res;
        sb = (int'(set_bits_reg) > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_bits_reg);
        ob = int'(off_bits_reg);
        nways = active_ways();
        set_idx = '0;
        tag = '0;
        if (ob < ADDR_W) begin
            set_idx = (addr >> ob) & ((64'd1 << sb) - 64'd1);
        end
        if (ob + sb < ADDR_W) begin
            tag = addr >> (ob + sb);
        end
        base = int'(set_idx[SET_BITS_MAX-1:0]) * WAYS_MAX;
        hit = 1'b0;
        evict = 1'b0;
        way = 0;
        for (w = 0; w < nways; w++) begin
            if (!hit && tag_valid[base + w] && tag_store[base + w] == tag) begin
                hit = 1'b1;
                way = w;
            end
        end
        if (hit) begin
            r = lru_rank[base + way];
            for (w = 0; w < nways; w++) begin
                if (w != way && tag_valid[base + w] && lru_rank[base + w] < r) begin
                    lru_rank[base + w] = lru_rank[base + w] + 3'd1;
                end
            end
            lru_rank[base + way] = '0;
            hit_tally = count_up(hit_tally);
        end else begin
            free_found = 1'b0;
            best = -1;
            miss_tally = count_up(miss_tally);
            for (w = 0; w < nways; w++) begin
                if (!free_found) begin
                    if (!tag_valid[base + w]) begin
                        free_found = 1'b1;
                        way = w;
                    end else if (int'(lru_rank[base + w]) > best) begin
                        best = int'(lru_rank[base + w]);
                        way = w;
                    end
                end
            end
            if (free_found) begin
                for (w = 0; w < nways; w++) begin
                    if (w != way && tag_valid[base + w]
                        && int'(lru_rank[base + w]) < WAYS_MAX - 1) begin
                        lru_rank[base + w] = lru_rank[base + w] + 3'd1;
                    end
                end
            end else begin
                r = lru_rank[base + way];
                for (w = 0; w < nways; w++) begin
                    if (w != way && tag_valid[base + w] && lru_rank[base + w] < r) begin
                        lru_rank[base + w] = lru_rank[base + w] + 3'd1;
                    end
                end
                evict = 1'b1;
                evict_count = count_up(evict_count);
            end
            tag_valid[base + way] = 1'b1;
            tag_store[base + way] = tag;
            lru_rank[base + way] = '0;
        end
        res.was_hit = hit;
        res.evicted = evict;
        res.way_used = 3'(way);
        res.hit_total = hit_tally;
        res.miss_total = miss_tally;
        res.eviction_total = evict_count;
        res.last_of_run = last_one;
        return res;
    endfunction

    function automatic sacl_pkg::t_out typed_result(input logic hit, input logic ev,
                                                    input int way, input int hits,
                                                    input int misses, input int evs);
        sacl_pkg::t_out res;
        res.was_hit = hit;
        res.evicted = ev;
        res.way_used = 3'(way);
        res.hit_total = sacl_pkg::TOTAL_W'(hits);
        res.miss_total = sacl_pkg::TOTAL_W'(misses);
        res.eviction_total = sacl_pkg::TOTAL_W'(evs);
        res.last_of_run = 1'b1;
        return res;
    endfunction

    task automatic add_row(input logic is_cfg, input logic [sacl_pkg::OP_W-1:0] code,
                           input logic [sacl_pkg::IN_ADDR_W-1:0] value,
                           input logic has_typed, input sacl_pkg::t_out typed);
        t_stim_row row;
        row.is_cfg = is_cfg;
        row.code = code;
        row.value = value;
        row.has_typed = has_typed;
        row.typed = typed;
        stim_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                 cycle_count, what, want, got);
    endtask

    // One access beat is taken at a rising edge with start high and busy low.
    task automatic do_access(input logic [sacl_pkg::OP_W-1:0] op,
                             input logic [sacl_pkg::IN_ADDR_W-1:0] addr,
                             input logic has_typed, input sacl_pkg::t_out typed);
        sacl_pkg::t_out res;
        while (allow_idle && $urandom_range(0, 99) < 35) begin
            start = 1'b0;
            i_in.operation = sacl_pkg::OP_W'($urandom);
            i_in.address = {$urandom, $urandom};
            @(negedge i_clk);
        end
        start = 1'b1;
        i_in.operation = op;
        i_in.address = addr;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (op == sacl_pkg::OP_LOAD || op == sacl_pkg::OP_STORE) begin
            res = lru_lookup(addr, 1'b1);
            pending_results.push_back(has_typed ? typed : res);
            accesses_done++;
        end else if (op == sacl_pkg::OP_MODIFY) begin
            pending_results.push_back(lru_lookup(addr, 1'b0));
            res = lru_lookup(addr, 1'b1);
            pending_results.push_back(has_typed ? typed : res);
            accesses_done++;
        end else begin
            ignored_done++;
        end
        @(negedge i_clk);
    endtask

    task automatic do_config(input logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sacl_pkg::CFG_DATA_W-1:0] data);
        while (allow_idle && $urandom_range(0, 99) < 35) begin
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        unique case (idx)
            sacl_pkg::CFG_SET_BITS: set_bits_reg = data[sacl_pkg::SETB_W-1:0];
            sacl_pkg::CFG_WAYS:     ways_reg = data[sacl_pkg::WAYS_W-1:0];
            sacl_pkg::CFG_OFF_BITS: off_bits_reg = data[sacl_pkg::OFFB_W-1:0];
            default:                ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_quiet();
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        sacl_pkg::t_out want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result strobe with nothing pending", 64'd0, 64'd1);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_result.was_hit !== want.was_hit)
                    report_mismatch("was_hit", want.was_hit, o_result.was_hit);
                if (o_result.evicted !== want.evicted)
                    report_mismatch("evicted", want.evicted, o_result.evicted);
                if (o_result.way_used !== want.way_used)
                    report_mismatch("way_used", want.way_used, o_result.way_used);
                if (o_result.hit_total !== want.hit_total)
                    report_mismatch("hit_total", want.hit_total, o_result.hit_total);
                if (o_result.miss_total !== want.miss_total)
                    report_mismatch("miss_total", want.miss_total, o_result.miss_total);
                if (o_result.eviction_total !== want.eviction_total)
                    report_mismatch("eviction_total", want.eviction_total,
                                    o_result.eviction_total);
                if (o_result.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", want.last_of_run, o_result.last_of_run);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results pending",
                 cycle_count, pending_results.size());
        $display("** set_assoc_cache_lru_sim: FAILED **");
        $finish;
    end

    initial begin
        int                        phase;
        int                        done;
        int                        k;
        int                        p;
        int                        sb;
        int                        ob;
        int                        nways;
        int                        sb_val;
        int                        ways_val;
        int                        ob_val;
        int                        random_items;
        logic [ADDR_W-1:0]         tag_pool [10];
        logic [ADDR_W-1:0]         addr;
        logic [ADDR_W-1:0]         set_part;
        logic [sacl_pkg::OP_W-1:0] op;
        t_stim_row                 row;

        for (k = 0; k < LINES; k++) begin
            tag_valid[k] = 1'b0;
            tag_store[k] = '0;
            lru_rank[k] = '0;
        end
        hit_tally = '0;
        miss_tally = '0;
        evict_count = '0;
        set_bits_reg = sacl_pkg::RST_SET_BITS;
        ways_reg = sacl_pkg::RST_WAYS;
        off_bits_reg = sacl_pkg::RST_OFF_BITS;

        add_row(1'b0, sacl_pkg::OP_LOAD,   64'h0,    1'b1, typed_result(0, 0, 0, 0, 1, 0));
        add_row(1'b0, sacl_pkg::OP_STORE,  64'hF,    1'b1, typed_result(1, 0, 0, 1, 1, 0));
        add_row(1'b0, sacl_pkg::OP_LOAD,   ALL_ONES, 1'b1, typed_result(0, 0, 0, 1, 2, 0));
        add_row(1'b0, sacl_pkg::OP_MODIFY, 64'h100,  1'b1, typed_result(1, 0, 0, 2, 3, 1));
        add_row(1'b0, OP_UNKNOWN,          ALL_ONES, 1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_LOAD,   64'h0,    1'b1, typed_result(0, 1, 0, 2, 4, 2));
        add_row(1'b1, sacl_pkg::CFG_WAYS,  64'd8,    1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_LOAD,   64'h100,  1'b1, typed_result(0, 0, 1, 2, 5, 2));
        for (k = 2; k <= 8; k++) begin
            add_row(1'b0, sacl_pkg::OP_LOAD, 64'(k) << 8, 1'b0, '0);
        end
        add_row(1'b0, sacl_pkg::OP_LOAD,      64'h0,                   1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_STORE,     64'h300,                 1'b0, '0);
        add_row(1'b1, sacl_pkg::CFG_SET_BITS, 64'd0,                   1'b0, '0);
        add_row(1'b1, sacl_pkg::CFG_OFF_BITS, 64'd0,                   1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_LOAD,      ALL_ONES,                1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_LOAD,      64'h8000_0000_0000_0000, 1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_STORE,     ALL_ONES,                1'b0, '0);
        add_row(1'b1, sacl_pkg::CFG_OFF_BITS, 64'd63,                  1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_LOAD,      ALL_ONES,                1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_MODIFY,    64'h0,                   1'b0, '0);
        add_row(1'b1, sacl_pkg::CFG_SET_BITS, 64'h3F,                  1'b0, '0);
        add_row(1'b1, sacl_pkg::CFG_OFF_BITS, 64'd54,                  1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_LOAD,      64'hFFC0_0000_0000_0000, 1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_LOAD,      ALL_ONES,                1'b0, '0);
        add_row(1'b1, sacl_pkg::CFG_WAYS,     64'd0,                   1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_MODIFY,    64'h0123_4567_89AB_CDEF, 1'b0, '0);
        add_row(1'b1, sacl_pkg::CFG_WAYS,     64'h3F,                  1'b0, '0);
        add_row(1'b1, CFG_NONE,               64'h2A,                  1'b0, '0);
        add_row(1'b0, sacl_pkg::OP_LOAD,      64'h0123_4567_89AB_CDEF, 1'b0, '0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.is_cfg) begin
                start = 1'b0;
                wait_quiet();
                do_config(row.code, row.value[sacl_pkg::CFG_DATA_W-1:0]);
            end else begin
                do_access(row.code, row.value, row.has_typed, row.typed);
            end
        end

        random_items = 0;
        for (phase = 0; phase < PHASES; phase++) begin
            start = 1'b0;
            allow_idle = 1'b1;
            wait_quiet();
            if (phase == 0) begin
                sb_val = SET_BITS_MAX;
                ways_val = WAYS_MAX;
                ob_val = 2;
            end else if (phase == PHASES - 1) begin
                sb_val = 0;
                ways_val = 1;
                ob_val = 0;
            end else begin
                sb_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 4);
                ways_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 8);
                ob_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 8);
            end
            do_config(sacl_pkg::CFG_SET_BITS,
                      sacl_pkg::CFG_DATA_W'($urandom_range(0, 3) * 16 + sb_val));
            do_config(sacl_pkg::CFG_WAYS,
                      sacl_pkg::CFG_DATA_W'($urandom_range(0, 3) * 16 + ways_val));
            do_config(sacl_pkg::CFG_OFF_BITS, sacl_pkg::CFG_DATA_W'(ob_val));
            if ($urandom_range(0, 3) == 0) begin
                do_config(CFG_NONE, sacl_pkg::CFG_DATA_W'($urandom_range(0, 63)));
            end
            for (k = 0; k < 10; k++) begin
                tag_pool[k] = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'(k);
            end
            sb = (int'(set_bits_reg) > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_bits_reg);
            ob = int'(off_bits_reg);
            nways = active_ways();
            done = 0;
            while (done < PHASE_ITEMS) begin
                allow_idle = !(random_items >= 600 && random_items < 900);
                p = $urandom_range(0, 99);
                op = (p < 40) ? sacl_pkg::OP_LOAD : (p < 70) ? sacl_pkg::OP_STORE
                   : (p < 95) ? sacl_pkg::OP_MODIFY : OP_UNKNOWN;
                if ($urandom_range(0, 99) < 85) begin
                    set_part = ($urandom_range(0, 9) == 0) ? 64'($urandom)
                                                           : 64'($urandom_range(0, 2));
                    set_part = (set_part & ((64'd1 << sb) - 64'd1)) << ob;
                    addr = (tag_pool[$urandom_range(0, nways + 1)] << (ob + sb)) | set_part
                           | ({$urandom, $urandom} & ((64'd1 << ob) - 64'd1));
                end else begin
                    addr = {$urandom, $urandom};
                end
                do_access(op, addr, 1'b0, '0);
                if (op != OP_UNKNOWN) begin
                    done++;
                    random_items++;
                end
            end
        end

        start = 1'b0;
        allow_idle = 1'b1;
        wait_quiet();
        $display("Ran %0d accesses and %0d ignored codes over %0d register writes and %0d phases.",
                 accesses_done, ignored_done, cfg_writes, PHASES);
        $display("Checked %0d lookup results: %0d hits, %0d misses, %0d evictions.",
                 results_checked, hit_tally, miss_tally, evict_count);
        if (mismatch_count == 0) begin
            $display("** set_assoc_cache_lru_sim: PASSED **");
        end else begin
            $display("** set_assoc_cache_lru_sim: FAILED **");
        end
        $finish;
    end

endmodule
